/* rtl/core/oaq_pkg.sv */
// Package for the ordered alarm queue: sizes, command and result codes,
// controller states and the types shared by the queue modules.
// No dependencies.
`default_nettype none

package oaq_pkg;

  localparam int AlarmSlots = 16;
  localparam int SlotW      = $clog2(AlarmSlots);
  localparam int HandleW    = 4;
  localparam int TimeW      = 63;
  localparam int TagW       = 16;
  localparam int SeqW       = 32;
  localparam int DataW      = 88;

  typedef enum logic [1:0] {
    KIND_ADD       = 2'd0,
    KIND_CANCEL    = 2'd1,
    KIND_SET_TIME  = 2'd2,
    KIND_READ_TIME = 2'd3
  } oaq_kind_e;

  typedef enum logic [2:0] {
    RES_QUEUED    = 3'd0,
    RES_FIRED     = 3'd1,
    RES_CANCELLED = 3'd2,
    RES_NOT_FOUND = 3'd3,
    RES_TIME      = 3'd4,
    RES_FULL      = 3'd5
  } oaq_res_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CANCEL_RD,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_SCAN_DONE,
    ST_EMIT
  } oaq_state_e;

  typedef struct packed {
    oaq_res_e             event_res;
    logic [HandleW-1:0]   slot;
    logic [TagW-1:0]      tag;
    logic [TimeW-1:0]     time_now;
    logic                 last;
  } oaq_res_t;

  typedef struct packed {
    logic [SeqW-1:0]  seq;
    logic [TagW-1:0]  tag;
    logic [TimeW-1:0] wake;
  } oaq_entry_t;

  localparam int EntryW = $bits(oaq_entry_t);

endpackage

`default_nettype wire

/* rtl/core/oaq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module oaq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/oaq_ctrl.sv */
// Alarm queue controller: command decode, slot valid bits, current time,
// sequence counter and the minimum scan over the alarm RAM.
// Depends on oaq_pkg and oaq_ram.
`default_nettype none

module oaq_ctrl import oaq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_valid_i,
  output logic                    cmd_ready_o,
  input  wire oaq_kind_e          cmd_kind_i,
  input  wire logic [TimeW-1:0]   cmd_time_i,
  input  wire logic [TagW-1:0]    cmd_tag_i,
  input  wire logic [HandleW-1:0] cmd_handle_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output oaq_res_t                res_o
);

  oaq_state_e state_q, state_d;

  logic [TimeW-1:0]      now_q, now_d;
  logic [SeqW-1:0]       seq_q, seq_d;
  logic [AlarmSlots-1:0] valid_q, valid_d;

  oaq_kind_e          kind_q, kind_d;
  logic [TimeW-1:0]   tval_q, tval_d;
  logic [TagW-1:0]    tag_q, tag_d;
  logic [HandleW-1:0] handle_q, handle_d;
  oaq_res_t           res_q, res_d;

  logic [SlotW-1:0] idx_q, idx_d;
  logic             pipe_act_q, pipe_act_d;
  logic             pipe_vld_q, pipe_vld_d;
  logic [SlotW-1:0] pipe_idx_q, pipe_idx_d;
  logic             best_found_q, best_found_d;
  logic [TimeW-1:0] best_wake_q, best_wake_d;
  logic [SeqW-1:0]  best_seq_q, best_seq_d;
  logic [TagW-1:0]  best_tag_q, best_tag_d;
  logic [SlotW-1:0] best_idx_q, best_idx_d;

  logic             ram_we, ram_re;
  logic [SlotW-1:0] ram_waddr, ram_raddr;
  oaq_entry_t       ram_wdata, ram_rdata;

  logic             free_any;
  logic [SlotW-1:0] free_idx;
  logic [SlotW-1:0] hidx;
  logic             hit;
  logic             better;
  logic             fire;
  logic             scan_last;

  oaq_ram #(
    .Width(EntryW),
    .Depth(AlarmSlots)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Lowest free slot.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = AlarmSlots - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  assign hidx      = SlotW'(handle_q);
  assign hit       = (int'(handle_q) < AlarmSlots) && valid_q[hidx];
  assign scan_last = (idx_q == SlotW'(AlarmSlots - 1));
  assign fire      = best_found_q && (best_wake_q <= tval_q);

  // A candidate wins on an earlier wakeup, or on the same wakeup with a lower sequence.
  assign better = !best_found_q || (ram_rdata.wake < best_wake_q) ||
                  ((ram_rdata.wake == best_wake_q) && (ram_rdata.seq < best_seq_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (kind_q == KIND_SET_TIME) begin
          state_d = ST_SCAN;
        end else if (kind_q == KIND_CANCEL && hit) begin
          state_d = ST_CANCEL_RD;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_CANCEL_RD: state_d = ST_EMIT;
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_SCAN_TAIL;
        end
      end
      ST_SCAN_TAIL: state_d = ST_SCAN_DONE;
      ST_SCAN_DONE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = res_q.last ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    now_d        = now_q;
    seq_d        = seq_q;
    valid_d      = valid_q;
    kind_d       = kind_q;
    tval_d       = tval_q;
    tag_d        = tag_q;
    handle_d     = handle_q;
    res_d        = res_q;
    idx_d        = idx_q;
    best_found_d = best_found_q;
    best_wake_d  = best_wake_q;
    best_seq_d   = best_seq_q;
    best_tag_d   = best_tag_q;
    best_idx_d   = best_idx_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = free_idx;
    ram_raddr    = idx_q;
    ram_wdata    = '{seq: seq_q, tag: tag_q, wake: tval_q};

    pipe_act_d = (state_q == ST_SCAN);
    pipe_vld_d = valid_q[idx_q];
    pipe_idx_d = idx_q;

    // Compare stage of the scan, one slot per cycle behind the RAM read.
    if (pipe_act_q && pipe_vld_q && better) begin
      best_found_d = 1'b1;
      best_wake_d  = ram_rdata.wake;
      best_seq_d   = ram_rdata.seq;
      best_tag_d   = ram_rdata.tag;
      best_idx_d   = pipe_idx_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          kind_d   = cmd_kind_i;
          tval_d   = cmd_time_i;
          tag_d    = cmd_tag_i;
          handle_d = cmd_handle_i;
        end
      end
      ST_DECODE: begin
        unique case (kind_q)
          KIND_ADD: begin
            if (tval_q <= now_q) begin
              res_d = '{event_res: RES_FIRED, slot: '0, tag: tag_q,
                        time_now: now_q, last: 1'b1};
            end else if (!free_any) begin
              res_d = '{event_res: RES_FULL, slot: '0, tag: tag_q,
                        time_now: now_q, last: 1'b1};
            end else begin
              ram_we            = 1'b1;
              valid_d[free_idx] = 1'b1;
              seq_d             = seq_q + SeqW'(1);
              res_d = '{event_res: RES_QUEUED, slot: HandleW'(free_idx), tag: tag_q,
                        time_now: now_q, last: 1'b1};
            end
          end
          KIND_CANCEL: begin
            if (hit) begin
              ram_re        = 1'b1;
              ram_raddr     = hidx;
              valid_d[hidx] = 1'b0;
            end else begin
              res_d = '{event_res: RES_NOT_FOUND, slot: '0, tag: '0,
                        time_now: now_q, last: 1'b1};
            end
          end
          KIND_SET_TIME: begin
            idx_d        = '0;
            best_found_d = 1'b0;
          end
          KIND_READ_TIME: begin
            res_d = '{event_res: RES_TIME, slot: '0, tag: '0,
                      time_now: now_q, last: 1'b1};
          end
          default: ;
        endcase
      end
      ST_CANCEL_RD: begin
        res_d = '{event_res: RES_CANCELLED, slot: handle_q, tag: ram_rdata.tag,
                  time_now: now_q, last: 1'b1};
      end
      ST_SCAN: begin
        ram_re = 1'b1;
        if (!scan_last) begin
          idx_d = idx_q + SlotW'(1);
        end
      end
      ST_SCAN_TAIL: ;
      ST_SCAN_DONE: begin
        if (fire) begin
          valid_d[best_idx_q] = 1'b0;
          now_d               = best_wake_q;
          res_d = '{event_res: RES_FIRED, slot: HandleW'(best_idx_q), tag: best_tag_q,
                    time_now: best_wake_q, last: 1'b0};
        end else begin
          now_d = (tval_q > now_q) ? tval_q : now_q;
          res_d = '{event_res: RES_TIME, slot: '0, tag: '0,
                    time_now: now_d, last: 1'b1};
        end
      end
      ST_EMIT: begin
        // After a firing the whole table is scanned again.
        if (res_ready_i && !res_q.last) begin
          idx_d        = '0;
          best_found_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      now_q        <= '0;
      seq_q        <= '0;
      valid_q      <= '0;
      idx_q        <= '0;
      pipe_act_q   <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      now_q        <= now_d;
      seq_q        <= seq_d;
      valid_q      <= valid_d;
      idx_q        <= idx_d;
      pipe_act_q   <= pipe_act_d;
      best_found_q <= best_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    tval_q      <= tval_d;
    tag_q       <= tag_d;
    handle_q    <= handle_d;
    res_q       <= res_d;
    pipe_vld_q  <= pipe_vld_d;
    pipe_idx_q  <= pipe_idx_d;
    best_wake_q <= best_wake_d;
    best_seq_q  <= best_seq_d;
    best_tag_q  <= best_tag_d;
    best_idx_q  <= best_idx_d;
  end

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_EMIT);
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_time_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> now_q >= $past(now_q))
    else $error("current time moved back");

  a_one_add_per_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $countones(valid_q) <= $countones($past(valid_q)) + 1)
    else $error("more than one slot filled in a cycle");

  a_fired_slot_freed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_DONE) && fire |=> !valid_q[$past(best_idx_q)])
    else $error("fired alarm still pending");

  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && !res_ready_i |=> (state_q == ST_EMIT) && $stable(res_q))
    else $error("pending result lost");
`endif

endmodule

`default_nettype wire

/* rtl/core/oaq_out.sv */
// Output register stage of the alarm queue: holds one result and packs it
// onto the master stream. Depends on oaq_pkg.
`default_nettype none

module oaq_out import oaq_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              res_valid_i,
  output logic                   res_ready_o,
  input  wire oaq_res_t          res_i,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [DataW-1:0]  m_axis_tdata,
  output logic      [2:0]        m_axis_tuser,
  output logic                   m_axis_tlast
);

  logic     out_vld_q, out_vld_d;
  oaq_res_t out_res_q;
  logic     load;

  assign res_ready_o = !out_vld_q || m_axis_tready;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_res_q <= res_i;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_res_q.event_res;
  assign m_axis_tlast  = out_res_q.last;
  assign m_axis_tdata  = DataW'({out_res_q.time_now, out_res_q.tag, out_res_q.slot});

endmodule

`default_nettype wire

/* rtl/core/ordered_alarm_queue.sv */
// Ordered alarm queue top level. Add, cancel and read time give one result each and
// take the next command once that result has been passed to the output stage.
// Set time is decoded first, then the RAM is scanned once per fired alarm and once
// again for the closing time report: every result needs a full minimum scan of the RAM.
// Reset empties the table and clears time and sequence; the alarm RAM is not cleared.
// Depends on oaq_pkg, oaq_ctrl, oaq_out and oaq_ram.
`default_nettype none

module ordered_alarm_queue import oaq_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // {pad, alarm_handle[82:79], alarm_tag[78:63], time_value[62:0]}
  input  wire logic [DataW-1:0] s_axis_tdata,
  // kind
  input  wire logic [1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // {pad, time_now[82:20], tag_out[19:4], slot[3:0]}
  output logic      [DataW-1:0] m_axis_tdata,
  // event_res
  output logic      [2:0]       m_axis_tuser,
  output logic                  m_axis_tlast
);

  logic     res_valid, res_ready;
  oaq_res_t res;

  oaq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_kind_i  (oaq_kind_e'(s_axis_tuser)),
    .cmd_time_i  (s_axis_tdata[TimeW-1:0]),
    .cmd_tag_i   (s_axis_tdata[TimeW+TagW-1:TimeW]),
    .cmd_handle_i(s_axis_tdata[TimeW+TagW+HandleW-1:TimeW+TagW]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  oaq_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_ready_o  (res_ready),
    .res_i        (res),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* tb/alarm_queue_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the ordered alarm queue. It watches both stream channels, predicts
// the events for each accepted command and compares every result transfer.
// Depends on oaq_pkg.
module alarm_queue_checker import oaq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  // {pad, alarm_handle, alarm_tag, time_value}
  input  logic [DataW-1:0] s_axis_tdata,
  // kind
  input  logic [1:0]       s_axis_tuser,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // {pad, time_now, tag_out, slot}
  input  logic [DataW-1:0] m_axis_tdata,
  // event_res
  input  logic [2:0]       m_axis_tuser,
  input  logic             m_axis_tlast,
  output int               fail_count_o,
  output int               pending_o
);

  logic [TimeW-1:0] now_us;
  logic             armed    [AlarmSlots];
  logic [TimeW-1:0] wake_at  [AlarmSlots];
  logic [TagW-1:0]  tag_of   [AlarmSlots];
  logic [SeqW-1:0]  order_no [AlarmSlots];
  logic [SeqW-1:0]  next_order;
  oaq_res_t         due_events[$];

  function automatic void post_event(oaq_res_e code, logic [HandleW-1:0] slot,
                                     logic [TagW-1:0] tag, logic last);
    oaq_res_t ev;
    ev.event_res = code;
    ev.slot      = slot;
    ev.tag       = tag;
    ev.time_now  = now_us;
    ev.last      = last;
    due_events.push_back(ev);
  endfunction

  task automatic predict_command(input oaq_kind_e kind, input logic [TimeW-1:0] tv,
                                 input logic [TagW-1:0] tg,
                                 input logic [HandleW-1:0] handle);
    int pick;
    bit more;
    case (kind)
      KIND_ADD: begin
        pick = -1;
        for (int i = AlarmSlots - 1; i >= 0; i--) begin
          if (!armed[i]) pick = i;
        end
        if (tv <= now_us) begin
          post_event(RES_FIRED, '0, tg, 1'b1);
        end else if (pick < 0) begin
          post_event(RES_FULL, '0, tg, 1'b1);
        end else begin
          armed[pick]    = 1'b1;
          wake_at[pick]  = tv;
          tag_of[pick]   = tg;
          order_no[pick] = next_order;
          next_order++;
          post_event(RES_QUEUED, HandleW'(pick), tg, 1'b1);
        end
      end
      KIND_CANCEL: begin
        if (int'(handle) < AlarmSlots && armed[handle]) begin
          armed[handle] = 1'b0;
          post_event(RES_CANCELLED, handle, tag_of[handle], 1'b1);
        end else begin
          post_event(RES_NOT_FOUND, '0, '0, 1'b1);
        end
      end
      KIND_SET_TIME: begin
        // Fire in (wakeup, sequence) order; each firing pulls the time along.
        more = 1'b1;
        while (more) begin
          pick = -1;
          for (int i = 0; i < AlarmSlots; i++) begin
            if (armed[i] && (pick < 0 || wake_at[i] < wake_at[pick] ||
                (wake_at[i] == wake_at[pick] && order_no[i] < order_no[pick])))
              pick = i;
          end
          more = pick >= 0 && wake_at[pick] <= tv;
          if (more) begin
            armed[pick] = 1'b0;
            now_us      = wake_at[pick];
            post_event(RES_FIRED, HandleW'(pick), tag_of[pick], 1'b0);
          end
        end
        if (now_us < tv) now_us = tv;
        post_event(RES_TIME, '0, '0, 1'b1);
      end
      KIND_READ_TIME: post_event(RES_TIME, '0, '0, 1'b1);
    endcase
  endtask

  function automatic void check_field(string name, logic [TimeW-1:0] want,
                                      logic [TimeW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i) begin : watch
    oaq_res_t want;
    if (!rst_ni) begin
      now_us     = '0;
      next_order = '0;
      foreach (armed[i]) armed[i] = 1'b0;
      due_events.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_command(oaq_kind_e'(s_axis_tuser), s_axis_tdata[TimeW-1:0],
                        s_axis_tdata[TimeW+TagW-1:TimeW],
                        s_axis_tdata[TimeW+TagW+HandleW-1:TimeW+TagW]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_events.size() == 0) begin
          $error("unexpected result transfer: event_res %0d, time_now %0d",
                 m_axis_tuser, m_axis_tdata[HandleW+TagW+TimeW-1:HandleW+TagW]);
          fail_count_o++;
        end else begin
          want = due_events.pop_front();
          check_field("event_res", TimeW'(want.event_res), TimeW'(m_axis_tuser));
          check_field("slot", TimeW'(want.slot), TimeW'(m_axis_tdata[HandleW-1:0]));
          check_field("tag_out", TimeW'(want.tag),
                      TimeW'(m_axis_tdata[HandleW+TagW-1:HandleW]));
          check_field("time_now", want.time_now,
                      m_axis_tdata[HandleW+TagW+TimeW-1:HandleW+TagW]);
          check_field("last", TimeW'(want.last), TimeW'(m_axis_tlast));
        end
      end
    end
    pending_o = due_events.size();
  end

endmodule

/* tb/ordered_alarm_queue_test.sv */
`timescale 1ns / 1ps
// Top of the ordered alarm queue testbench: clock, reset, command stimulus and the
// result receiver. Depends on oaq_pkg, ordered_alarm_queue and alarm_queue_checker.
module ordered_alarm_queue_test;
  import oaq_pkg::*;

  localparam logic [TimeW-1:0] TimeMax = '1;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata  = '0;
  logic [1:0]       s_axis_tuser  = KIND_READ_TIME;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;
  logic [2:0]       m_axis_tuser;
  logic             m_axis_tlast;

  int               fail_count;
  int               pending;
  int               sent;
  bit               quiet;
  bit               stall_rx;
  // Largest set-time target issued so far; the block's time reaches it once that command completes.
  logic [TimeW-1:0] clock_us = '0;

  ordered_alarm_queue DUT (.*);

  alarm_queue_checker u_alarm_check (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #9_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [TimeW-1:0] rand_time();
    return TimeW'({$urandom, $urandom});
  endfunction

  function automatic logic [TimeW-1:0] ahead(int unsigned span);
    return clock_us + TimeW'($urandom_range(0, span));
  endfunction

  // A wakeup that is already due.
  function automatic logic [TimeW-1:0] behind();
    logic [TimeW-1:0] t;
    t = clock_us - TimeW'($urandom_range(0, 64));
    if (t > clock_us) t = '0;
    return t;
  endfunction

  task automatic send_cmd(input oaq_kind_e kind, input logic [TimeW-1:0] tv,
                          input logic [TagW-1:0] tg, input logic [HandleW-1:0] handle);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(DataW - HandleW - TagW - TimeW){1'b0}}, handle, tg, tv};
    do @(posedge clk_i); while (!s_axis_tready);
    if (kind == KIND_SET_TIME && tv > clock_us) clock_us = tv;
    sent++;
  endtask

  // Result receiver: random stalls, one long hold-off on request, none at the end.
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_rx) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        stall_rx = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!quiet && rst_ni && $urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned      scene;
    int unsigned      span;
    logic [TimeW-1:0] tie_at;
    oaq_kind_e        kind;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: due adds, ties broken by sequence rather than slot, cancels of
    // queued and free slots, a set time that goes backward.
    send_cmd(KIND_READ_TIME, '0, '0, '0);
    send_cmd(KIND_ADD, '0, '0, '0);
    send_cmd(KIND_ADD, TimeMax, 16'hFFFF, '1);
    send_cmd(KIND_ADD, TimeW'(100), 16'h1234, '0);
    send_cmd(KIND_ADD, TimeW'(100), 16'h5678, '0);
    send_cmd(KIND_ADD, TimeW'(50), 16'hAAAA, '0);
    send_cmd(KIND_CANCEL, '0, '0, 4'd0);
    send_cmd(KIND_CANCEL, '0, '0, 4'd0);
    send_cmd(KIND_CANCEL, TimeMax, 16'hFFFF, 4'd15);
    send_cmd(KIND_ADD, TimeW'(100), 16'h0F0F, '0);
    send_cmd(KIND_SET_TIME, TimeW'(100), '0, '0);
    send_cmd(KIND_SET_TIME, TimeW'(40), '0, '0);
    send_cmd(KIND_ADD, TimeW'(100), 16'hC3C3, '0);
    send_cmd(KIND_ADD, TimeW'(99), 16'h3C3C, '0);
    send_cmd(KIND_ADD, TimeW'(101), 16'h5A5A, '0);
    send_cmd(KIND_ADD, TimeMax, 16'hA5A5, '0);
    send_cmd(KIND_READ_TIME, TimeMax, 16'hFFFF, '1);
    send_cmd(KIND_CANCEL, '0, '0, 4'd1);

    for (int round = 0; sent < 352; round++) begin
      if (sent >= 300) quiet = 1'b1;
      // Start with two table fills; the second runs into the long receiver hold-off.
      scene = (round < 2) ? 5 : $urandom_range(0, 9);
      if (round == 1) stall_rx = 1'b1;
      span = 16 << (3 * $urandom_range(0, 5));
      case (scene)
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 5) == 0)
              send_cmd(KIND_ADD, behind(), 16'($urandom), 4'($urandom));
            else
              send_cmd(KIND_ADD, ahead(span), 16'($urandom), 4'($urandom));
            if ($urandom_range(0, 3) == 0)
              send_cmd(KIND_CANCEL, rand_time(), 16'($urandom), 4'($urandom));
          end
          send_cmd(KIND_SET_TIME, ahead(span), 16'($urandom), 4'($urandom));
          if ($urandom_range(0, 3) == 0)
            send_cmd(KIND_READ_TIME, rand_time(), 16'($urandom), 4'($urandom));
        end
        4: begin
          tie_at = ahead(64) + 1;
          repeat ($urandom_range(2, 6))
            send_cmd(KIND_ADD, tie_at, 16'($urandom), 4'($urandom));
          if ($urandom_range(0, 1) == 0)
            send_cmd(KIND_CANCEL, rand_time(), 16'($urandom), 4'($urandom));
          send_cmd(KIND_SET_TIME, tie_at, 16'($urandom), 4'($urandom));
        end
        5: begin
          repeat (AlarmSlots + 2)
            send_cmd(KIND_ADD, ahead(4096) + 1, 16'($urandom), 4'($urandom));
          send_cmd(KIND_SET_TIME, clock_us + 4097, 16'($urandom), 4'($urandom));
        end
        6: begin
          send_cmd(KIND_ADD, rand_time(), 16'($urandom), 4'($urandom));
          repeat (2) send_cmd(KIND_CANCEL, rand_time(), 16'($urandom), 4'($urandom));
        end
        7: begin
          repeat (3) begin
            kind = oaq_kind_e'($urandom_range(0, 3));
            if (kind == KIND_ADD || kind == KIND_SET_TIME)
              send_cmd(kind, $urandom_range(0, 1) ? ahead(256) : behind(),
                       16'($urandom), 4'($urandom));
            else
              send_cmd(kind, rand_time(), 16'($urandom), 4'($urandom));
          end
        end
        8: begin
          repeat ($urandom_range(2, 6))
            send_cmd(KIND_CANCEL, rand_time(), 16'($urandom), 4'($urandom));
        end
        default: begin
          send_cmd(KIND_SET_TIME, behind(), 16'($urandom), 4'($urandom));
          send_cmd(KIND_READ_TIME, rand_time(), 16'($urandom), 4'($urandom));
        end
      endcase
    end

    // Push the time into the upper half of its range and then to the very top,
    // which drains every alarm still queued.
    quiet = 1'b1;
    send_cmd(KIND_SET_TIME, {1'b1, 30'($urandom), 32'($urandom)}, '0, '0);
    send_cmd(KIND_ADD, TimeMax, 16'($urandom), 4'($urandom));
    send_cmd(KIND_ADD, TimeMax - 1, 16'($urandom), 4'($urandom));
    send_cmd(KIND_SET_TIME, TimeMax, 16'($urandom), 4'($urandom));
    send_cmd(KIND_ADD, TimeMax, 16'hFFFF, '1);
    send_cmd(KIND_ADD, '0, '0, '0);
    send_cmd(KIND_READ_TIME, '0, '0, '0);
    s_axis_tvalid <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
